// ===== src/face_interpolation_coefficients_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Face interpolation coefficients: assertion macros
// Concurrent assertion shorthands clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef FACE_INTERPOLATION_COEFFICIENTS_UNIT_MACROS_SVH
`define FACE_INTERPOLATION_COEFFICIENTS_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define FIC_ASSERT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fic: check failed");

// next-cycle implication, off during reset
`define FIC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fic: next-cycle check failed");

// next-cycle implication, always active
`define FIC_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("fic: reset check failed");

`endif

// ===== src/fic_pkg.sv =====
// ----------------------------------------------------------------------------
// Face interpolation coefficients: package
// Transaction payload types and fixed-point constants.
// ----------------------------------------------------------------------------
`default_nettype none

package fic_pkg;

    localparam logic [30:0] WEIGHT_ONE  = 31'h4000_0000;
    localparam logic [30:0] WEIGHT_HALF = 31'h2000_0000;

    typedef struct packed {
        logic               is_boundary;
        logic signed [31:0] face_cx;
        logic signed [31:0] face_cy;
        logic signed [31:0] owner_cx;
        logic signed [31:0] owner_cy;
        logic signed [31:0] nbr_cx;
        logic signed [31:0] nbr_cy;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
    } fic_in_t;

    typedef struct packed {
        logic        [30:0] weight;
        logic signed [31:0] inv_proj;
        logic signed [31:0] corr_x;
        logic signed [31:0] corr_y;
        logic signed [31:0] skew_x;
        logic signed [31:0] skew_y;
    } fic_out_t;

endpackage

`default_nettype wire

// ===== src/face_interpolation_coefficients_unit.sv =====
// ----------------------------------------------------------------------------
// Face interpolation coefficients unit
// Pipelined weight, delta coefficient, correction and skewness per mesh face.
// ----------------------------------------------------------------------------
// Usage:
//   One face enters per s_valid/s_ready transaction on s_data; one result
//   leaves per m_valid/m_ready transaction on m_data, in the same order.
//   cfg_wen/cfg_wdata write min_projection (Q16.16, reset value 1) and may
//   only be written while the unit holds no face in flight.
//   The pipeline has 73 register stages, the first loaded at the accepting
//   edge. The longest path sets their number: a 33-step bitwise square
//   root on both distances followed by a 31-step restoring divider for
//   the weight, one step per register stage.
//   Throughput is one face per cycle while m_ready stays high.
//   When m_ready drops, the pending result moves into a skid register and
//   the whole pipeline holds; s_ready goes low the next cycle and rises
//   again once the skid register drains. Nothing is lost or repeated.
//   Reset (aresetn low, synchronous) empties the pipeline and the skid
//   register and sets min_projection back to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module face_interpolation_coefficients_unit (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wen,
    input  wire logic [15:0]      cfg_wdata,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire fic_pkg::fic_in_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output fic_pkg::fic_out_t     m_data
);

    localparam int SQ_N     = 33;
    localparam int WD_N     = 31;
    localparam int DD_N     = 32;
    localparam int ST_SUM   = 4;
    localparam int ST_CFIN  = 8;
    localparam int ST_DFIN  = ST_SUM + DD_N + 2;
    localparam int ST_TOT   = ST_SUM + SQ_N + 1;
    localparam int ST_WFIN  = ST_TOT + WD_N + 1;
    localparam int ST_WMUL  = ST_WFIN + 1;
    localparam int ST_WRND  = ST_WMUL + 1;
    localparam int LAT      = ST_WRND + 1;

    typedef struct packed {
        logic               bnd;
        logic signed [32:0] dox;
        logic signed [32:0] doy;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
    } carry_t;

    typedef struct packed {
        logic signed [31:0] delta;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
    } res_t;

    typedef struct packed {
        logic [35:0] rem;
        logic [32:0] root;
        logic [65:0] rad;
    } sq_t;

    typedef struct packed {
        logic [34:0] r;
        logic [30:0] q;
        logic [33:0] d;
        logic        deg;
    } wd_t;

    typedef struct packed {
        logic [64:0] r;
        logic [31:0] q;
        logic [63:0] d;
        logic        neg;
        logic        deg;
        logic        sat;
    } dd_t;

    function automatic logic signed [31:0] clamp_n(input logic signed [31:0] v);
        if (v > 32'sd1073741824) begin
            return 32'sd1073741824;
        end else if (v < -32'sd1073741824) begin
            return -32'sd1073741824;
        end
        return v;
    endfunction

    function automatic logic [31:0] abs33(input logic signed [32:0] v);
        logic [32:0] t;
        t = v[32] ? (33'd0 - v) : v;
        return t[31:0];
    endfunction

    // round to nearest on a 30-bit right shift, halves away from zero
    function automatic logic signed [67:0] rnd30(input logic signed [67:0] v);
        logic [67:0] m;
        logic [67:0] r;
        m = v[67] ? (68'd0 - v) : v;
        r = (m + 68'd536870912) >> 30;
        return v[67] ? $signed(68'd0 - r) : $signed(r);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -36'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic sq_t sq_step(input sq_t a);
        sq_t         o;
        logic [37:0] rem_s;
        logic [32:0] root_s;
        logic [33:0] test;
        logic        ge;
        rem_s  = {a.rem, a.rad[65:64]};
        root_s = {a.root[31:0], 1'b0};
        test   = {root_s, 1'b1};
        ge     = rem_s >= {4'b0, test};
        rem_s  = ge ? (rem_s - {4'b0, test}) : rem_s;
        o.rem  = rem_s[35:0];
        o.root = root_s | {32'b0, ge};
        o.rad  = {a.rad[63:0], 2'b00};
        return o;
    endfunction

    function automatic wd_t wd_step(input wd_t a);
        wd_t         o;
        logic        ge;
        logic [34:0] rn;
        ge    = a.r >= {1'b0, a.d};
        rn    = ge ? (a.r - {1'b0, a.d}) : a.r;
        o     = a;
        o.r   = {rn[33:0], 1'b0};
        o.q   = {a.q[29:0], ge};
        return o;
    endfunction

    function automatic dd_t dd_step(input dd_t a);
        dd_t         o;
        logic        ge;
        logic [64:0] rn;
        ge    = a.r >= {1'b0, a.d};
        rn    = ge ? (a.r - {1'b0, a.d}) : a.r;
        o     = a;
        o.r   = {rn[63:0], 1'b0};
        o.q   = {a.q[30:0], ge};
        return o;
    endfunction

    logic                en;
    logic [15:0]         min_reg;
    logic [LAT:1]        vld_reg;
    carry_t              carry_reg [1:LAT-1];
    carry_t              c1;
    logic signed [32:0]  ex1, ey1;

    logic signed [32:0]  ex_reg, ey_reg, pvx1_reg, pvy1_reg;
    logic [31:0]         ao_reg, bo_reg, an_reg, bn_reg;
    logic signed [32:0]  pvx2_reg, pvy2_reg;
    logic [63:0]         sqa_reg, sqb_reg, sqc_reg, sqd_reg;
    logic signed [64:0]  prx_reg, pry_reg;
    logic [64:0]         so_reg, sn_reg;
    logic signed [63:0]  p46_reg;
    logic signed [65:0]  p_sum;

    sq_t                 sqo_reg [0:SQ_N-1];
    sq_t                 sqn_reg [0:SQ_N-1];
    logic [33:0]         tot_reg;
    logic [32:0]         dn_reg;
    logic                wdeg_reg;
    wd_t                 wd_reg [0:WD_N-1];
    logic [30:0]         w_reg, w2_reg, w3_reg;
    logic signed [64:0]  wx_reg, wy_reg;
    logic signed [35:0]  kx_reg, ky_reg;

    logic [63:0]         dm_reg;
    logic                dneg_reg, ddeg_reg, dsat_reg;
    dd_t                 dd_reg [0:DD_N-1];
    logic signed [31:0]  delta_fin;
    logic signed [34:0]  p16_reg;
    logic signed [66:0]  pcx_reg, pcy_reg;
    logic signed [35:0]  rcx_reg, rcy_reg;
    res_t                res_reg [ST_CFIN:LAT-1];

    fic_pkg::fic_out_t   out_reg, skid_reg;
    logic                skid_vld_reg;

    // the whole pipeline holds only while the skid register is occupied
    assign en      = ~skid_vld_reg;
    assign s_ready = en;
    assign m_valid = skid_vld_reg | vld_reg[LAT];
    assign m_data  = skid_vld_reg ? skid_reg : out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg <= 16'd1;
        end else if (cfg_wen) begin
            min_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-1:1], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_vld_reg <= 1'b0;
        end else if (skid_vld_reg) begin
            if (m_ready) begin
                skid_vld_reg <= 1'b0;
            end
        end else if (vld_reg[LAT] && !m_ready) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && vld_reg[LAT] && !m_ready) begin
            skid_reg <= out_reg;
        end
    end

    // stage 1: coordinate differences and normal clamp
    always_comb begin
        c1.bnd = s_data.is_boundary;
        c1.dox = {s_data.face_cx[31], s_data.face_cx} - {s_data.owner_cx[31], s_data.owner_cx};
        c1.doy = {s_data.face_cy[31], s_data.face_cy} - {s_data.owner_cy[31], s_data.owner_cy};
        c1.dx  = {s_data.nbr_cx[31], s_data.nbr_cx} - {s_data.owner_cx[31], s_data.owner_cx};
        c1.dy  = {s_data.nbr_cy[31], s_data.nbr_cy} - {s_data.owner_cy[31], s_data.owner_cy};
        c1.nx  = clamp_n(s_data.normal_x);
        c1.ny  = clamp_n(s_data.normal_y);
        ex1    = {s_data.face_cx[31], s_data.face_cx} - {s_data.nbr_cx[31], s_data.nbr_cx};
        ey1    = {s_data.face_cy[31], s_data.face_cy} - {s_data.nbr_cy[31], s_data.nbr_cy};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            carry_reg[1] <= c1;
            ex_reg       <= ex1;
            ey_reg       <= ey1;
            // boundary faces project the face-minus-owner vector
            pvx1_reg     <= c1.bnd ? c1.dox : c1.dx;
            pvy1_reg     <= c1.bnd ? c1.doy : c1.dy;
        end
    end

    genvar k;
    generate
        for (k = 2; k < LAT; k++) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    carry_reg[k] <= carry_reg[k-1];
                end
            end
        end
    endgenerate

    // stages 2 to 4: magnitudes, products, sums
    always_comb begin
        p_sum = prx_reg + pry_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ao_reg   <= abs33(carry_reg[1].dox);
            bo_reg   <= abs33(carry_reg[1].doy);
            an_reg   <= abs33(ex_reg);
            bn_reg   <= abs33(ey_reg);
            pvx2_reg <= pvx1_reg;
            pvy2_reg <= pvy1_reg;

            sqa_reg  <= ao_reg * ao_reg;
            sqb_reg  <= bo_reg * bo_reg;
            sqc_reg  <= an_reg * an_reg;
            sqd_reg  <= bn_reg * bn_reg;
            prx_reg  <= pvx2_reg * carry_reg[2].nx;
            pry_reg  <= pvy2_reg * carry_reg[2].ny;

            so_reg   <= {1'b0, sqa_reg} + {1'b0, sqb_reg};
            sn_reg   <= {1'b0, sqc_reg} + {1'b0, sqd_reg};
            p46_reg  <= p_sum[63:0];
        end
    end

    // square root: one result bit per stage for both distances
    genvar j;
    generate
        for (j = 0; j < SQ_N; j++) begin : g_sqrt
            sq_t o_in, n_in;
            if (j == 0) begin : g_first
                assign o_in = '{rem: '0, root: '0, rad: {1'b0, so_reg}};
                assign n_in = '{rem: '0, root: '0, rad: {1'b0, sn_reg}};
            end else begin : g_next
                assign o_in = sqo_reg[j-1];
                assign n_in = sqn_reg[j-1];
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    sqo_reg[j] <= sq_step(o_in);
                    sqn_reg[j] <= sq_step(n_in);
                end
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (en) begin
            tot_reg  <= {1'b0, sqo_reg[SQ_N-1].root} + {1'b0, sqn_reg[SQ_N-1].root};
            dn_reg   <= sqn_reg[SQ_N-1].root;
            wdeg_reg <= ({1'b0, sqo_reg[SQ_N-1].root} + {1'b0, sqn_reg[SQ_N-1].root})
                        <= {18'b0, min_reg};
        end
    end

    // weight divider: dn * 2^30 / tot, one quotient bit per stage
    generate
        for (j = 0; j < WD_N; j++) begin : g_wdiv
            wd_t w_in;
            if (j == 0) begin : g_first
                assign w_in = '{r: {2'b0, dn_reg}, q: '0, d: tot_reg, deg: wdeg_reg};
            end else begin : g_next
                assign w_in = wd_reg[j-1];
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    wd_reg[j] <= wd_step(w_in);
                end
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (en) begin
            if (carry_reg[ST_WFIN-1].bnd) begin
                w_reg <= fic_pkg::WEIGHT_ONE;
            end else if (wd_reg[WD_N-1].deg) begin
                w_reg <= fic_pkg::WEIGHT_HALF;
            end else begin
                w_reg <= wd_reg[WD_N-1].q;
            end
            w2_reg <= w_reg;
            wx_reg <= $signed({1'b0, w_reg}) * carry_reg[ST_WMUL-1].dx;
            wy_reg <= $signed({1'b0, w_reg}) * carry_reg[ST_WMUL-1].dy;
            w3_reg <= w2_reg;
            kx_reg <= 36'(rnd30(68'(wx_reg)));
            ky_reg <= 36'(rnd30(68'(wy_reg)));
        end
    end

    // delta coefficient: 2^62 / |projection|
    always_ff @(posedge aclk) begin
        if (en) begin
            dm_reg   <= p46_reg[63] ? (64'd0 - p46_reg) : p46_reg;
            dneg_reg <= p46_reg[63];
            ddeg_reg <= (p46_reg[63] ? (64'd0 - p46_reg) : p46_reg)
                        <= {18'b0, min_reg, 30'b0};
            dsat_reg <= (p46_reg[63] ? (64'd0 - p46_reg) : p46_reg) <= 64'h8000_0000;
            p16_reg  <= 35'(rnd30(68'(p46_reg)));
        end
    end

    generate
        for (j = 0; j < DD_N; j++) begin : g_ddiv
            dd_t d_in;
            if (j == 0) begin : g_first
                assign d_in = '{r: 65'h0_8000_0000, q: '0, d: dm_reg,
                                neg: dneg_reg, deg: ddeg_reg, sat: dsat_reg};
            end else begin : g_next
                assign d_in = dd_reg[j-1];
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    dd_reg[j] <= dd_step(d_in);
                end
            end
        end
    endgenerate

    always_comb begin
        if (dd_reg[DD_N-1].deg) begin
            delta_fin = '0;
        end else if (dd_reg[DD_N-1].sat) begin
            delta_fin = dd_reg[DD_N-1].neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else if (dd_reg[DD_N-1].neg) begin
            delta_fin = 32'd0 - dd_reg[DD_N-1].q;
        end else begin
            delta_fin = dd_reg[DD_N-1].q;
        end
    end

    // non-orthogonal correction
    always_ff @(posedge aclk) begin
        if (en) begin
            pcx_reg <= p16_reg * carry_reg[ST_SUM+1].nx;
            pcy_reg <= p16_reg * carry_reg[ST_SUM+1].ny;
            rcx_reg <= 36'(rnd30(68'(pcx_reg)));
            rcy_reg <= 36'(rnd30(68'(pcy_reg)));
        end
    end

    generate
        for (k = ST_CFIN; k < LAT; k++) begin : g_res
            always_ff @(posedge aclk) begin
                if (en) begin
                    if (k == ST_CFIN) begin
                        res_reg[k].delta <= '0;
                        res_reg[k].cx    <= carry_reg[k-1].bnd ? 32'sd0 :
                            sat32(36'(carry_reg[k-1].dx) - rcx_reg);
                        res_reg[k].cy    <= carry_reg[k-1].bnd ? 32'sd0 :
                            sat32(36'(carry_reg[k-1].dy) - rcy_reg);
                    end else if (k == ST_DFIN) begin
                        res_reg[k].delta <= delta_fin;
                        res_reg[k].cx    <= res_reg[k-1].cx;
                        res_reg[k].cy    <= res_reg[k-1].cy;
                    end else begin
                        res_reg[k] <= res_reg[k-1];
                    end
                end
            end
        end
    endgenerate

    // output stage: skewness and assembly
    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg.weight   <= w3_reg;
            out_reg.inv_proj <= res_reg[LAT-1].delta;
            out_reg.corr_x   <= res_reg[LAT-1].cx;
            out_reg.corr_y   <= res_reg[LAT-1].cy;
            out_reg.skew_x   <= carry_reg[LAT-1].bnd ? 32'sd0 :
                sat32(36'(carry_reg[LAT-1].dox) - kx_reg);
            out_reg.skew_y   <= carry_reg[LAT-1].bnd ? 32'sd0 :
                sat32(36'(carry_reg[LAT-1].doy) - ky_reg);
        end
    end

endmodule

`default_nettype wire

// ===== src/fic_checker.sv =====
// ----------------------------------------------------------------------------
// Face interpolation coefficients: port checker
// Watches the result channel and stall behavior of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "face_interpolation_coefficients_unit_macros.svh"

module fic_checker (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_ready,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire fic_pkg::fic_out_t m_data
);

    // a stalled transaction keeps its payload
    `FIC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))

    // reset empties the pipeline and frees the input side
    `FIC_ASSERT_RST(a_reset_empty, !aresetn, !m_valid && s_ready)

    // weight never exceeds one
    `FIC_ASSERT(a_weight_range, m_valid, m_data.weight <= fic_pkg::WEIGHT_ONE)

    // input side only backs off after an output stall
    `FIC_ASSERT(a_stall_cause, !s_ready, $past(m_valid && !m_ready))

endmodule

bind face_interpolation_coefficients_unit fic_checker u_fic_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
